// ===== sv/efd_pkg.sv =====
// efd_pkg: constants shared by the error diffusion dither block.
// No dependencies; used by sv/error_diffusion_dither.sv.
`default_nettype none

package efd_pkg;

   // payload and register widths fixed by the interface
   localparam int PIXEL_W   = 8;
   localparam int SIZE_W    = 13;
   localparam int ROW_W     = 12;
   localparam int CSR_IDX_W = 4;

   // frame height limit and register reset values
   localparam int MAX_HEIGHT = 4096;
   localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = SIZE_W'(480);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = CSR_IDX_W'(1);

   // shares are error * k / 16, floored
   localparam int SHARE_SHIFT = 4;

endpackage

`default_nettype wire

// ===== sv/error_diffusion_dither.sv =====
// error_diffusion_dither: error diffusion dither, 8-bit gray to 1-bit.
// Depends on efd_pkg (sv/efd_pkg.sv).
//
// Usage
//   req_*  : gray pixels in raster order, one per transfer (valid/ready).
//   rsp_*  : one result per pixel: out_bit (1 = white), row_end, frame_end.
//   csr_*  : register writes, index 0 frame_width, index 1 frame_height.
//            Always ready; write only while no pixel is in flight.
// Timing
//   A transferred pixel passes the input stage and then the result register
//   before its result shows on rsp_*. One pixel per clock is sustained while
//   rsp_ready stays high: the whole working-value / threshold / share update
//   fits between the input stage and the result register, and the error line
//   memory has one read and one write each cycle.
// Stall
//   The result register holds while rsp_ready is low; the input stage still
//   takes one more pixel, then req_ready drops until the result is taken.
// Reset
//   Sizes return to 640 x 480, counters and carries clear. The error line
//   is not swept: a fill count marks how many columns were written in the
//   current frame, and columns past it read as zero. The count also clears
//   at every frame end, so no clearing pass is needed and the block is
//   ready as soon as reset is released.
`default_nettype none

module error_diffusion_dither #(
   parameter int MAX_WIDTH = 4096,
   parameter int FRAC_BITS = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [efd_pkg::PIXEL_W-1:0]     req_gray_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_out_bit,
   output logic                            rsp_row_end,
   output logic                            rsp_frame_end,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [efd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [efd_pkg::SIZE_W-1:0]      csr_wdata
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int FILL_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = ((FILL_W > efd_pkg::SIZE_W) ? FILL_W : efd_pkg::SIZE_W) + 1;
   localparam int H_W    = efd_pkg::SIZE_W + 1;
   localparam int ERR_W  = FRAC_BITS + 12;
   localparam int XW     = ERR_W + 6;   // working width, room for error * 7

   localparam logic [CMP_W-1:0] MAX_W_C = CMP_W'(MAX_WIDTH);
   localparam logic [H_W-1:0]   MAX_H_C = H_W'(efd_pkg::MAX_HEIGHT);
   localparam logic signed [XW-1:0] FULL_SCALE = XW'(255 * (2 ** FRAC_BITS));
   localparam logic signed [XW-1:0] ERR_HI = XW'((2 ** (ERR_W - 1)) - 1);
   localparam logic signed [XW-1:0] ERR_LO = -ERR_HI - XW'(1);

   function automatic logic signed [ERR_W-1:0] sat_err(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] r;
      begin
         if (v > ERR_HI) begin
            r = ERR_HI;
         end else if (v < ERR_LO) begin
            r = ERR_LO;
         end else begin
            r = v;
         end
         sat_err = r[ERR_W-1:0];
      end
   endfunction

   // ---------------------------------------------------------------- config
   logic [efd_pkg::SIZE_W-1:0] frame_width_ff, frame_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= efd_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= efd_pkg::FRAME_HEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            efd_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            efd_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;   // unknown index: write dropped
         endcase
      end
   end

   // Clamp sizes: zero acts as one, oversize acts as the limit.
   logic [CMP_W-1:0] w_ext, eff_w;
   logic [H_W-1:0]   h_ext, eff_h;

   always_comb begin
      w_ext = CMP_W'(frame_width_ff);
      h_ext = H_W'(frame_height_ff);
      if (w_ext == '0) begin
         eff_w = CMP_W'(1);
      end else if (w_ext > MAX_W_C) begin
         eff_w = MAX_W_C;
      end else begin
         eff_w = w_ext;
      end
      if (h_ext == '0) begin
         eff_h = H_W'(1);
      end else if (h_ext > MAX_H_C) begin
         eff_h = MAX_H_C;
      end else begin
         eff_h = h_ext;
      end
   end

   // ------------------------------------------------------- handshake/stages
   logic a_valid_ff, rsp_valid_ff;
   logic a_xfer, req_xfer;

   assign a_xfer    = a_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !a_valid_ff || a_xfer;
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // ------------------------------------------------ position, taken at entry
   logic [COL_W-1:0] col_cnt_ff, col_cnt_in;
   logic [efd_pkg::ROW_W-1:0] row_cnt_ff, row_cnt_in;
   logic [COL_W-1:0] req_col;
   logic req_last_col, req_last_row;
   logic [CMP_W-1:0] col_ext;

   always_comb begin
      col_ext      = CMP_W'(col_cnt_ff);
      req_last_col = (col_ext + CMP_W'(1)) >= eff_w;
      req_last_row = (H_W'(row_cnt_ff) + H_W'(1)) >= eff_h;
      // a shrunken width pins the column to the new last one
      if (col_ext >= eff_w - CMP_W'(1)) begin
         req_col = COL_W'(eff_w - CMP_W'(1));
      end else begin
         req_col = col_cnt_ff;
      end
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      if (req_xfer) begin
         if (req_last_col) begin
            col_cnt_in = '0;
            row_cnt_in = req_last_row ? '0 : row_cnt_ff + efd_pkg::ROW_W'(1);
         end else begin
            col_cnt_in = req_col + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         row_cnt_ff <= row_cnt_in;
      end
   end

   // ------------------------------------------------------------ input stage
   logic [efd_pkg::PIXEL_W-1:0] a_pixel_ff;
   logic [COL_W-1:0]            a_col_ff;
   logic                        a_last_col_ff, a_last_row_ff;
   logic                        a_zero_ff;      // column past fill count
   logic                        byp_valid_ff;   // later write to our column
   logic signed [ERR_W-1:0]     byp_data_ff;
   logic signed [ERR_W-1:0]     mem_rd_ff;
   logic                        a_frame_end;

   assign a_frame_end = a_last_col_ff && a_last_row_ff;

   // error line write port
   logic                    wr_en;
   logic [COL_W-1:0]        wr_addr;
   logic signed [ERR_W-1:0] wr_data;
   logic [FILL_W-1:0]       fill_ff;
   logic                    frame_clear;

   // deferred last-column entry
   logic                    pend_valid_ff;
   logic [COL_W-1:0]        pend_addr_ff;
   logic signed [ERR_W-1:0] pend_data_ff;

   assign frame_clear = a_xfer && a_frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         a_valid_ff <= 1'b1;
      end else if (a_xfer) begin
         a_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else if (req_xfer) begin
         byp_valid_ff <= wr_en && (wr_addr == req_col) && !frame_clear;
      end else if (wr_en && (wr_addr == a_col_ff)) begin
         byp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_pixel_ff    <= req_gray_pixel;
         a_col_ff      <= req_col;
         a_last_col_ff <= req_last_col;
         a_last_row_ff <= req_last_row;
         a_zero_ff     <= frame_clear || (FILL_W'(req_col) >= fill_ff);
         byp_data_ff   <= wr_data;
      end else if (wr_en && (wr_addr == a_col_ff)) begin
         byp_data_ff <= wr_data;
      end
   end

   // ------------------------------------------------------- error line memory
   logic signed [ERR_W-1:0] err_line [MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         err_line[wr_addr] <= wr_data;
      end
      if (req_xfer) begin
         mem_rd_ff <= err_line[req_col];
      end
   end

   // ------------------------------------------------------------ datapath
   logic signed [ERR_W-1:0] right_carry_ff, right_carry_in;
   logic signed [ERR_W-1:0] below_left_ff, below_left_in;
   logic signed [ERR_W-1:0] below_ff, below_in;
   logic signed [ERR_W-1:0] below_err, left_wr_data, blp_new;
   logic signed [XW-1:0]    pix_x, val, err, e7, e3, e5;
   logic signed [XW-1:0]    s7, s3, s5, s1;
   logic                    white;

   always_comb begin
      if (pend_valid_ff && (pend_addr_ff == a_col_ff)) begin
         // one-column frame: the entry from the row above lands this cycle
         below_err = pend_data_ff;
      end else if (byp_valid_ff) begin
         below_err = byp_data_ff;
      end else if (a_zero_ff) begin
         below_err = '0;
      end else begin
         below_err = mem_rd_ff;
      end

      pix_x = XW'(signed'({1'b0, a_pixel_ff, {FRAC_BITS{1'b0}}}));
      val   = pix_x + XW'(right_carry_ff) + XW'(below_err);
      white = (val <<< 1) >= FULL_SCALE;
      err   = val - (white ? FULL_SCALE : '0);

      e7 = (err <<< 3) - err;
      e3 = (err <<< 1) + err;
      e5 = (err <<< 2) + err;
      s7 = e7 >>> efd_pkg::SHARE_SHIFT;
      s3 = e3 >>> efd_pkg::SHARE_SHIFT;
      s5 = e5 >>> efd_pkg::SHARE_SHIFT;
      s1 = err >>> efd_pkg::SHARE_SHIFT;
      if (a_last_row_ff) begin
         // bottom row: nothing goes below
         s3 = '0;
         s5 = '0;
         s1 = '0;
      end

      left_wr_data = sat_err(XW'(below_left_ff) + s3);
      blp_new      = sat_err(XW'(below_ff) + s5);

      right_carry_in = right_carry_ff;
      below_left_in  = below_left_ff;
      below_in       = below_ff;
      if (a_xfer) begin
         if (a_last_col_ff) begin
            right_carry_in = '0;
            below_left_in  = '0;
            below_in       = '0;
         end else begin
            right_carry_in = sat_err(s7);
            below_left_in  = blp_new;
            below_in       = sat_err(s1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_carry_ff <= '0;
         below_left_ff  <= '0;
         below_ff       <= '0;
      end else begin
         right_carry_ff <= right_carry_in;
         below_left_ff  <= below_left_in;
         below_ff       <= below_in;
      end
   end

   // Last column stores two entries; the one for the current column is held in
   // the pend register and written on its own, as a column-zero pixel writes nothing.
   logic                    left_wr;

   assign left_wr = a_xfer && (a_col_ff != '0) && !a_frame_end;

   always_comb begin
      wr_en   = pend_valid_ff || left_wr;
      wr_addr = a_col_ff - COL_W'(1);
      wr_data = left_wr_data;
      if (pend_valid_ff) begin
         wr_addr = pend_addr_ff;
         wr_data = pend_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= a_xfer && a_last_col_ff && !a_last_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_xfer) begin
         pend_addr_ff <= a_col_ff;
         pend_data_ff <= blp_new;
      end
   end

   // Columns are written as a growing prefix, so one count marks validity.
   always_ff @(posedge clock) begin
      if (reset || frame_clear) begin
         fill_ff <= '0;
      end else if (wr_en && (FILL_W'(wr_addr) == fill_ff)) begin
         fill_ff <= fill_ff + FILL_W'(1);
      end
   end

   // ------------------------------------------------------- result register
   logic out_bit_ff, row_end_ff, frame_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (a_xfer) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (a_xfer) begin
         out_bit_ff   <= white;
         row_end_ff   <= a_last_col_ff;
         frame_end_ff <= a_frame_end;
      end
   end

   assign rsp_out_bit   = out_bit_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

`default_nettype wire
